/* sv/biq_pkg.sv */
// shared constants, types and the microcode program of the stereo biquad filter
// no dependencies; the rtl files refer to it by scoped names, the testbench imports it
package biq_pkg;

  localparam int CHANNELS       = 2;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 28;

  localparam int COEF_W     = 32;
  localparam int DELAY_BITS = 48;
  localparam int DELAY_FRAC = 24;
  localparam int NUM_REGS   = 5;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // multiplier operand holds a sample or one half of a delay-scale value
  localparam int OPND_W  = ((SAMPLE_BITS > DELAY_FRAC) ? SAMPLE_BITS : DELAY_FRAC) + 1;
  localparam int PROD_W  = COEF_W + OPND_W;
  localparam int V_W     = ((SAMPLE_BITS + DELAY_FRAC) > DELAY_BITS) ?
                           (SAMPLE_BITS + DELAY_FRAC) : DELAY_BITS;
  localparam int PACC_W  = COEF_W + V_W;
  localparam int SUM_W   = DELAY_BITS + 2;
  localparam int R_W     = DELAY_BITS - DELAY_FRAC + 1;
  localparam int RC_W    = ((R_W > SAMPLE_BITS) ? R_W : SAMPLE_BITS) + 1;

  localparam int NUM_STEPS = 12;
  localparam int PC_W      = $clog2(NUM_STEPS);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_B0,
    REG_B1,
    REG_B2,
    REG_A1,
    REG_A2
  } reg_idx_e;

  typedef enum logic [1:0] {
    OPND_X,
    OPND_YL,
    OPND_YH
  } opnd_e;

  typedef enum logic [1:0] {
    PA_HOLD,
    PA_LOAD_LO,
    PA_LOAD_HI,
    PA_ADD_HI
  } pacc_op_e;

  typedef enum logic [2:0] {
    SUM_HOLD,
    SUM_FD_P,
    SUM_SD_P,
    SUM_ADD,
    SUM_SUB,
    SUM_NEG
  } sum_op_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_Y,
    WR_FD,
    WR_SD
  } wr_e;

  typedef enum logic {
    JMP_NEXT,
    JMP_END
  } jmp_e;

  typedef struct packed {
    logic     mul_en;
    reg_idx_e coef_sel;
    opnd_e    opnd;
    pacc_op_e pacc_op;
    sum_op_e  sum_op;
    wr_e      wr;
    logic     clr;
    jmp_e     jmp;
  } ctrl_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   channel;
    logic                   clipped;
  } result_t;

  typedef logic [NUM_REGS-1:0][COEF_W-1:0] coef_arr_t;

  localparam coef_arr_t COEF_RESET =
    coef_arr_t'((NUM_REGS * COEF_W)'(1) << COEF_FRAC_BITS);

  localparam ctrl_t UCODE_NOP = '{
    mul_en:   1'b0,
    coef_sel: REG_B0,
    opnd:     OPND_X,
    pacc_op:  PA_HOLD,
    sum_op:   SUM_HOLD,
    wr:       WR_NONE,
    clr:      1'b0,
    jmp:      JMP_NEXT
  };

  // y = b0*x + fd ; fd = b1*x - a1*y + sd ; sd = b2*x - a2*y
  function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] step);
    ctrl_t w;
    w = UCODE_NOP;
    unique case (step)
      PC_W'(0): begin
        w.mul_en = 1'b1; w.coef_sel = REG_B0; w.opnd = OPND_X;
        w.clr = 1'b1;
      end
      PC_W'(1): begin
        w.pacc_op = PA_LOAD_HI;
        w.mul_en = 1'b1; w.coef_sel = REG_B1; w.opnd = OPND_X;
      end
      PC_W'(2): begin
        w.sum_op = SUM_FD_P;
        w.pacc_op = PA_LOAD_HI;
      end
      PC_W'(3): begin
        w.wr = WR_Y;
        w.sum_op = SUM_SD_P;
      end
      PC_W'(4): begin
        w.mul_en = 1'b1; w.coef_sel = REG_A1; w.opnd = OPND_YL;
      end
      PC_W'(5): begin
        w.mul_en = 1'b1; w.coef_sel = REG_A1; w.opnd = OPND_YH;
        w.pacc_op = PA_LOAD_LO;
      end
      PC_W'(6): begin
        w.pacc_op = PA_ADD_HI;
        w.mul_en = 1'b1; w.coef_sel = REG_A2; w.opnd = OPND_YL;
      end
      PC_W'(7): begin
        w.sum_op = SUM_SUB;
        w.pacc_op = PA_LOAD_LO;
        w.mul_en = 1'b1; w.coef_sel = REG_A2; w.opnd = OPND_YH;
      end
      PC_W'(8): begin
        w.wr = WR_FD;
        w.pacc_op = PA_ADD_HI;
        w.mul_en = 1'b1; w.coef_sel = REG_B2; w.opnd = OPND_X;
      end
      PC_W'(9): begin
        w.sum_op = SUM_NEG;
        w.pacc_op = PA_LOAD_HI;
      end
      PC_W'(10): begin
        w.sum_op = SUM_ADD;
      end
      PC_W'(11): begin
        w.wr = WR_SD;
        w.jmp = JMP_END;
      end
      default: begin
        w = UCODE_NOP;
      end
    endcase
    return w;
  endfunction

endpackage

/* sv/biq_if.sv */
// valid/ready stream interfaces for input and result items
// depends on biq_pkg for the sample width
interface biq_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [biq_pkg::SAMPLE_BITS-1:0] sample_in;
  logic                            channel_sel;
  logic                            clear_delays;

  modport source (output valid, output sample_in, output channel_sel,
                  output clear_delays, input ready);
  modport sink   (input valid, input sample_in, input channel_sel,
                  input clear_delays, output ready);
endinterface

interface biq_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [biq_pkg::SAMPLE_BITS-1:0] sample_out;
  logic                            channel_out;
  logic                            clipped;

  modport source (output valid, output sample_out, output channel_out,
                  output clipped, input ready);
  modport sink   (input valid, input sample_out, input channel_out,
                  input clipped, output ready);
endinterface

/* sv/biq_sequencer.sv */
// step counter and microcode fetch; issues one control word per cycle while running,
// holding the end step while the output is busy; depends on biq_pkg for the program and the control word type
module biq_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           out_busy_i,
  output biq_pkg::ctrl_t ctrl_o,
  output logic           idle_o,
  output logic           done_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                      state_q, state_d;
  logic [biq_pkg::PC_W-1:0]  pc_q, pc_d;
  biq_pkg::ctrl_t            word;
  logic                      run;
  logic                      stall;

  always_comb begin
    word   = biq_pkg::ucode_rom(pc_q);
    run    = (state_q == ST_RUN);
    // end step holds while the output register is still full
    stall  = run && (word.jmp == biq_pkg::JMP_END) && out_busy_i;
    ctrl_o = (run && !stall) ? word : biq_pkg::UCODE_NOP;
    done_o = run && !stall && (word.jmp == biq_pkg::JMP_END);
    idle_o = !run;

    state_d = state_q;
    pc_d    = pc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RUN;
          pc_d    = '0;
        end
      end
      ST_RUN: begin
        if (!stall) begin
          if (word.jmp == biq_pkg::JMP_END) begin
            state_d = ST_IDLE;
          end else begin
            pc_d = pc_q + biq_pkg::PC_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

endmodule

/* sv/biq_datapath.sv */
// shared multiplier, product accumulator, sum register and per-channel delays
// depends on biq_pkg for widths and control word decoding
module biq_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [biq_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                   channel_i,
  input  logic                                   clear_i,
  input  biq_pkg::coef_arr_t                     coef_i,
  input  biq_pkg::ctrl_t                         ctrl_i,
  output biq_pkg::result_t                       result_o
);

  localparam int SB   = biq_pkg::SAMPLE_BITS;
  localparam int DB   = biq_pkg::DELAY_BITS;
  localparam int DF   = biq_pkg::DELAY_FRAC;
  localparam int YH_W = DB - DF;
  localparam logic [DB:0] RND = (DB + 1)'(1) << (DF - 1);

  logic signed [SB-1:0]                  x_q;
  logic                                  ch_q;
  logic [biq_pkg::CH_W-1:0]              ch_idx_q;
  logic                                  clr_q;
  logic signed [DB-1:0]                  y_q;
  logic signed [biq_pkg::PROD_W-1:0]     prod_q, prod_d;
  logic signed [biq_pkg::PACC_W-1:0]     pacc_q, pacc_d;
  logic signed [biq_pkg::SUM_W-1:0]      sum_q, sum_d;
  logic signed [DB-1:0]                  fd_q [biq_pkg::CHANNELS];
  logic signed [DB-1:0]                  sd_q [biq_pkg::CHANNELS];

  logic signed [biq_pkg::COEF_W-1:0]     coef_sel;
  logic signed [biq_pkg::OPND_W-1:0]     opnd;
  logic signed [biq_pkg::PACC_W-1:0]     prod_ext, prod_hi, pacc_sh;
  logic [biq_pkg::PACC_W-DB:0]           pacc_top;
  logic signed [DB-1:0]                  p;
  logic signed [biq_pkg::SUM_W-1:0]      p_ext, fd_ext, sd_ext;
  logic [biq_pkg::SUM_W-DB:0]            sum_top;
  logic signed [DB-1:0]                  sum_sat;
  logic [DB:0]                           y_rnd;
  logic [biq_pkg::RC_W-1:0]              r_ext;
  logic [biq_pkg::RC_W-SB:0]             r_top;
  logic                                  r_fits;

  // multiplier operand and product
  always_comb begin
    coef_sel = $signed(coef_i[ctrl_i.coef_sel]);
    unique case (ctrl_i.opnd)
      biq_pkg::OPND_X:  opnd = {{(biq_pkg::OPND_W - SB){x_q[SB-1]}}, x_q};
      biq_pkg::OPND_YL: opnd = {{(biq_pkg::OPND_W - DF){1'b0}}, y_q[DF-1:0]};
      biq_pkg::OPND_YH: opnd = {{(biq_pkg::OPND_W - YH_W){y_q[DB-1]}}, y_q[DB-1:DF]};
      default:          opnd = '0;
    endcase
    prod_d = coef_sel * opnd;
  end

  // full product accumulation, then floor to delay scale with saturation
  always_comb begin
    prod_ext = {{(biq_pkg::PACC_W - biq_pkg::PROD_W){prod_q[biq_pkg::PROD_W-1]}}, prod_q};
    prod_hi  = prod_ext <<< DF;
    unique case (ctrl_i.pacc_op)
      biq_pkg::PA_HOLD:    pacc_d = pacc_q;
      biq_pkg::PA_LOAD_LO: pacc_d = prod_ext;
      biq_pkg::PA_LOAD_HI: pacc_d = prod_hi;
      biq_pkg::PA_ADD_HI:  pacc_d = pacc_q + prod_hi;
      default:             pacc_d = pacc_q;
    endcase
    pacc_sh  = pacc_q >>> biq_pkg::COEF_FRAC_BITS;
    pacc_top = pacc_sh[biq_pkg::PACC_W-1:DB-1];
    p = ((&pacc_top) || !(|pacc_top)) ? pacc_sh[DB-1:0] :
        {pacc_sh[biq_pkg::PACC_W-1], {(DB-1){~pacc_sh[biq_pkg::PACC_W-1]}}};
  end

  // delay-scale sums
  always_comb begin
    p_ext  = {{(biq_pkg::SUM_W - DB){p[DB-1]}}, p};
    fd_ext = {{(biq_pkg::SUM_W - DB){fd_q[ch_idx_q][DB-1]}}, fd_q[ch_idx_q]};
    sd_ext = {{(biq_pkg::SUM_W - DB){sd_q[ch_idx_q][DB-1]}}, sd_q[ch_idx_q]};
    unique case (ctrl_i.sum_op)
      biq_pkg::SUM_HOLD: sum_d = sum_q;
      biq_pkg::SUM_FD_P: sum_d = fd_ext + p_ext;
      biq_pkg::SUM_SD_P: sum_d = sd_ext + p_ext;
      biq_pkg::SUM_ADD:  sum_d = sum_q + p_ext;
      biq_pkg::SUM_SUB:  sum_d = sum_q - p_ext;
      biq_pkg::SUM_NEG:  sum_d = -p_ext;
      default:           sum_d = sum_q;
    endcase
    sum_top = sum_q[biq_pkg::SUM_W-1:DB-1];
    sum_sat = ((&sum_top) || !(|sum_top)) ? sum_q[DB-1:0] :
              {sum_q[biq_pkg::SUM_W-1], {(DB-1){~sum_q[biq_pkg::SUM_W-1]}}};
  end

  // round half up and saturate to the sample width
  always_comb begin
    y_rnd  = {y_q[DB-1], y_q} + RND;
    r_ext  = {{(biq_pkg::RC_W - biq_pkg::R_W){y_rnd[DB]}}, y_rnd[DB:DF]};
    r_top  = r_ext[biq_pkg::RC_W-1:SB-1];
    r_fits = (&r_top) || !(|r_top);
    result_o.sample  = r_fits ? r_ext[SB-1:0] :
                       {r_ext[biq_pkg::RC_W-1], {(SB-1){~r_ext[biq_pkg::RC_W-1]}}};
    result_o.channel = ch_q;
    result_o.clipped = !r_fits;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= sample_i;
      ch_q  <= channel_i;
      clr_q <= clear_i;
      ch_idx_q <= (int'(channel_i) >= biq_pkg::CHANNELS) ?
                  biq_pkg::CH_W'(biq_pkg::CHANNELS - 1) : biq_pkg::CH_W'(channel_i);
    end
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    pacc_q <= pacc_d;
    sum_q  <= sum_d;
    if (ctrl_i.wr == biq_pkg::WR_Y) begin
      y_q <= sum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < biq_pkg::CHANNELS; i++) begin
        fd_q[i] <= '0;
        sd_q[i] <= '0;
      end
    end else begin
      if (ctrl_i.clr && clr_q) begin
        for (int i = 0; i < biq_pkg::CHANNELS; i++) begin
          fd_q[i] <= '0;
          sd_q[i] <= '0;
        end
      end
      if (ctrl_i.wr == biq_pkg::WR_FD) begin
        fd_q[ch_idx_q] <= sum_sat;
      end
      if (ctrl_i.wr == biq_pkg::WR_SD) begin
        sd_q[ch_idx_q] <= sum_sat;
      end
    end
  end

endmodule

/* sv/stereo_biquad_filter_top.sv */
// a result is taken into the output register when the end step of its item runs
// an item is accepted only while idle, so a new item waits until the 12-step program
// sharing one 32x25 multiplier is through; the last step waits while the output register is full
// reset: b0 = 1.0, other coefficients 0, all channel delays zero, no clearing pass
// depends on biq_pkg, biq_if, biq_sequencer and biq_datapath
module stereo_biquad_filter_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  biq_in_if.sink                          in_i,
  biq_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [biq_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  logic [biq_pkg::COEF_W-1:0]      cfg_data_i
);

  biq_pkg::coef_arr_t coef_q;
  biq_pkg::ctrl_t     ctrl;
  biq_pkg::result_t   result;
  biq_pkg::result_t   out_q;
  logic               out_valid_q;
  logic               idle;
  logic               done;
  logic               start;
  logic               out_busy;

  assign in_i.ready = idle;
  assign start      = in_i.valid && idle;
  assign out_busy   = out_valid_q && !out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= biq_pkg::COEF_RESET;
    end else if (cfg_we_i && (cfg_idx_i < biq_pkg::REG_IDX_W'(biq_pkg::NUM_REGS))) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  biq_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl),
    .idle_o     (idle),
    .done_o     (done)
  );

  biq_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .sample_i  (in_i.sample_in),
    .channel_i (in_i.channel_sel),
    .clear_i   (in_i.clear_delays),
    .coef_i    (coef_q),
    .ctrl_i    (ctrl),
    .result_o  (result)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= result;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.sample_out  = out_q.sample;
  assign out_o.channel_out = out_q.channel;
  assign out_o.clipped     = out_q.clipped;

endmodule

/* verif/stereo_biquad_filter_top_tb.sv */
// testbench for stereo_biquad_filter_top: random and directed samples over several coefficient sets
// a bit-accurate filter tracker predicts each output item; needs biq_pkg, biq_if and the rtl
module stereo_biquad_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import biq_pkg::*;

  localparam int ITEMS_PER_PHASE = 215;
  localparam int SETTLE_CYCLES   = 20;
  localparam int HOLD_CYCLES     = 400;
  localparam logic [COEF_W-1:0] Q_ONE   = COEF_W'(1) << COEF_FRAC_BITS;
  localparam logic [COEF_W-1:0] COEF_HI = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_LO = {1'b1, {(COEF_W-1){1'b0}}};
  localparam longint DELAY_MAX  = (64'sd1 <<< (DELAY_BITS-1)) - 1;
  localparam longint DELAY_MIN  = -DELAY_MAX - 1;
  localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS-1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  class biquad_tracker;
    logic signed [COEF_W-1:0]     taps [NUM_REGS];
    logic signed [DELAY_BITS-1:0] z1 [CHANNELS];
    logic signed [DELAY_BITS-1:0] z2 [CHANNELS];
    result_t filtered_q[$];
    int bad_outputs;

    function new();
      int k;
      for (k = 0; k < NUM_REGS; k++) taps[k] = '0;
      taps[REG_B0] = Q_ONE;
      for (k = 0; k < CHANNELS; k++) begin
        z1[k] = '0;
        z2[k] = '0;
      end
      bad_outputs = 0;
    endfunction

    function void set_tap(logic [REG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      if (idx < NUM_REGS) taps[idx] = data;
    endfunction

    function logic signed [DELAY_BITS-1:0] clamp_delay(logic signed [127:0] v);
      if (v > DELAY_MAX) return DELAY_BITS'(DELAY_MAX);
      if (v < DELAY_MIN) return DELAY_BITS'(DELAY_MIN);
      return v[DELAY_BITS-1:0];
    endfunction

    // coefficient times delay-scale value, floored back to the delay scale
    function logic signed [DELAY_BITS-1:0] scaled(logic signed [COEF_W-1:0] c,
                                                  logic signed [127:0] v);
      logic signed [127:0] cw;
      cw = c;
      return clamp_delay((cw * v) >>> COEF_FRAC_BITS);
    endfunction

    function void filter_sample(logic signed [SAMPLE_BITS-1:0] sample, logic ch, logic clr);
      logic signed [127:0] xv, yw, acc, rnd;
      logic signed [DELAY_BITS-1:0] y;
      result_t res;
      int k;
      if (clr) begin
        for (k = 0; k < CHANNELS; k++) begin
          z1[k] = '0;
          z2[k] = '0;
        end
      end
      k = (ch >= CHANNELS) ? CHANNELS - 1 : ch;
      xv = sample;
      xv = xv <<< DELAY_FRAC;
      acc = scaled(taps[REG_B0], xv);
      acc = acc + z1[k];
      y = clamp_delay(acc);
      yw = y;
      acc = scaled(taps[REG_B1], xv);
      acc = acc - scaled(taps[REG_A1], yw);
      acc = acc + z2[k];
      z1[k] = clamp_delay(acc);
      acc = scaled(taps[REG_B2], xv);
      acc = acc - scaled(taps[REG_A2], yw);
      z2[k] = clamp_delay(acc);
      rnd = (yw + (128'sd1 <<< (DELAY_FRAC-1))) >>> DELAY_FRAC;
      res.channel = ch;
      res.clipped = (rnd > SAMPLE_MAX) || (rnd < SAMPLE_MIN);
      if (rnd > SAMPLE_MAX) res.sample = SAMPLE_BITS'(SAMPLE_MAX);
      else if (rnd < SAMPLE_MIN) res.sample = SAMPLE_BITS'(SAMPLE_MIN);
      else res.sample = rnd[SAMPLE_BITS-1:0];
      filtered_q.push_back(res);
    endfunction

    function void compare_output(result_t got);
      result_t want;
      if (filtered_q.size() == 0) begin
        bad_outputs++;
        if (bad_outputs <= 10)
          $display("unexpected item: sample %0d channel %0b clipped %0b",
                   $signed(got.sample), got.channel, got.clipped);
        return;
      end
      want = filtered_q.pop_front();
      if (got.sample !== want.sample || got.channel !== want.channel ||
          got.clipped !== want.clipped) begin
        bad_outputs++;
        if (bad_outputs <= 10)
          $display("mismatch at %0t: sample exp %0d got %0d, channel exp %0b got %0b, clipped exp %0b got %0b",
                   $realtime, $signed(want.sample), $signed(got.sample),
                   want.channel, got.channel, want.clipped, got.clipped);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                 cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_idx_i;
  logic [COEF_W-1:0]    cfg_data_i;

  biq_in_if  in_if ();
  biq_out_if out_if ();

  biquad_tracker tracker = new();
  int send_burst = 0;
  int recv_burst = 0;

  stereo_biquad_filter_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_BITS'(SAMPLE_MAX);
      1: return SAMPLE_BITS'(SAMPLE_MIN);
      2: return SAMPLE_BITS'(int'($urandom_range(0, 512)) - 256);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic drive_item(logic [SAMPLE_BITS-1:0] sample, logic ch, logic clr);
    int gap;
    gap = pick_gap(send_burst);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.sample_in    <= sample;
    in_if.channel_sel  <= ch;
    in_if.clear_delays <= clr;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.filter_sample(sample, ch, clr);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (tracker.filtered_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_filter(logic [COEF_W-1:0] b0, logic [COEF_W-1:0] b1,
                                logic [COEF_W-1:0] b2, logic [COEF_W-1:0] a1,
                                logic [COEF_W-1:0] a2);
    logic [COEF_W-1:0]    vals [NUM_REGS];
    logic [COEF_W-1:0]    junk;
    logic [REG_IDX_W-1:0] bad_idx;
    reg_idx_e             r;
    int i;
    vals = '{b0, b1, b2, a1, a2};
    for (i = 0; i < NUM_REGS; i++) begin
      r = reg_idx_e'(i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= r;
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      tracker.set_tap(r, vals[i]);
    end
    // index past the register file, must be dropped
    bad_idx = REG_IDX_W'(NUM_REGS + $urandom_range(0, (1 << REG_IDX_W) - NUM_REGS - 1));
    junk = $urandom;
    cfg_idx_i  <= bad_idx;
    cfg_data_i <= junk;
    @(posedge clk_i);
    tracker.set_tap(bad_idx, junk);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_items(int count);
    int i;
    for (i = 0; i < count; i++)
      drive_item(pick_sample(), 1'($urandom), $urandom_range(0, 24) == 0);
  endtask

  initial begin
    logic [SAMPLE_BITS-1:0] pat [10];
    int i, p;
    pat = '{SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MIN), '0, '1,
            SAMPLE_BITS'(1), 24'haaaaaa, 24'h555555, SAMPLE_BITS'(SAMPLE_MAX - 1),
            SAMPLE_BITS'(SAMPLE_MIN + 1), 24'h000800};
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.sample_in    <= '0;
    in_if.channel_sel  <= 1'b0;
    in_if.clear_delays <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= '0;
    cfg_data_i         <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients pass samples through unchanged
    for (i = 0; i < 20; i++)
      drive_item(pat[i % 10], 1'(i) ^ 1'(i / 10), (i == 0) || (i == 13));
    random_items(ITEMS_PER_PHASE);

    for (p = 1; p <= 8; p++) begin
      drain();
      case (p)
        1: program_filter(COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI);
        2: program_filter(COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO);
        3: program_filter(32'sd67108864, 32'sd134217728, 32'sd67108864,
                          -32'sd134217728, 32'sd67108864);
        4: program_filter(32'sd2684355, 32'sd5368709, 32'sd2684355,
                          -32'sd510027366, 32'sd255013683);
        5: program_filter($urandom, $urandom, $urandom, $urandom, $urandom);
        6: program_filter(COEF_W'(int'($urandom_range(0, 32'h2000_0000)) - int'(Q_ONE)),
                          COEF_W'(int'($urandom_range(0, 32'h2000_0000)) - int'(Q_ONE)),
                          COEF_W'(int'($urandom_range(0, 32'h2000_0000)) - int'(Q_ONE)),
                          COEF_W'(int'($urandom_range(0, 32'h2000_0000)) - int'(Q_ONE)),
                          COEF_W'(int'($urandom_range(0, 32'h1000_0000)) - int'(Q_ONE >> 1)));
        7: program_filter(COEF_LO, COEF_HI, COEF_LO, '0, COEF_HI);
        default: program_filter(Q_ONE, '0, '0, '0, '0);
      endcase
      if (p == 1) begin
        // saturation of products, sums and the output
        drive_item(SAMPLE_BITS'(SAMPLE_MAX), 1'b0, 1'b1);
        drive_item(SAMPLE_BITS'(SAMPLE_MIN), 1'b1, 1'b0);
        drive_item(SAMPLE_BITS'(1), 1'b0, 1'b0);
        drive_item('1, 1'b1, 1'b0);
        drive_item('0, 1'b0, 1'b1);
      end
      random_items(ITEMS_PER_PHASE);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.bad_outputs == 0) begin
      $display("stereo_biquad_filter_top_tb: PASS");
    end else begin
      $display("stereo_biquad_filter_top_tb: FAIL");
    end
    $finish;
  end

  initial begin
    int gap, seen;
    result_t got;
    seen = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (seen == 250 || seen == 1100) begin
        // long hold-off so the block backs up into its input
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        gap = pick_gap(recv_burst);
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        out_if.ready <= 1'b1;
      end
      do @(posedge clk_i); while (!out_if.valid);
      got.sample  = out_if.sample_out;
      got.channel = out_if.channel_out;
      got.clipped = out_if.clipped;
      tracker.compare_output(got);
      seen++;
    end
  end

  initial begin
    #20_000_000;
    $display("stereo_biquad_filter_top_tb: FAIL");
    $finish;
  end

endmodule

/* sim.f */
sv/biq_pkg.sv
sv/biq_if.sv
sv/biq_sequencer.sv
sv/biq_datapath.sv
sv/stereo_biquad_filter_top.sv
verif/stereo_biquad_filter_top_tb.sv
